// ===== rtl/core/rss_pkg.sv =====
// Shared types, codes and ring geometry for the ring slot sequencer.
// No dependencies; imported by rss_engine and ring_slot_sequencer_core.
package rss_pkg;

    // Ring size is rounded up to a power of two
    localparam int unsigned RING_SLOTS = 16;
    localparam int unsigned RING_BITS  = $clog2(RING_SLOTS);
    localparam int unsigned RING_SIZE  = 1 << RING_BITS;
    localparam logic [31:0] RING_MASK  = 32'(RING_SIZE - 1);

    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned SLOT_W = 4;

    // Operation codes
    localparam logic [1:0] FN_CLAIM   = 2'd0;
    localparam logic [1:0] FN_COMMIT  = 2'd1;
    localparam logic [1:0] FN_READ    = 2'd2;
    localparam logic [1:0] FN_RELEASE = 2'd3;

    // Status codes
    localparam logic [1:0] STS_OK            = 2'd0;
    localparam logic [1:0] STS_FULL_RETRY    = 2'd1;
    localparam logic [1:0] STS_NOT_COMMITTED = 2'd2;
    localparam logic [1:0] STS_WRONG_STATE   = 2'd3;

    // Slot state codes
    localparam logic [1:0] SLOT_FREE      = 2'd0;
    localparam logic [1:0] SLOT_CLAIMED   = 2'd1;
    localparam logic [1:0] SLOT_COMMITTED = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [SEQ_W-1:0] seq_index;
    } rss_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SEQ_W-1:0]  granted_seq;
        logic [SLOT_W-1:0] slot_number;
    } rss_result_t;

endpackage

// ===== rtl/core/rss_engine.sv =====
// Sequencer state (cursor, last read sequence, slot states) and the
// single-pass decision logic for one transaction. Depends on rss_pkg.
module rss_engine
    import rss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  rss_req_t    req,
    output rss_result_t result
);

    logic [SEQ_W-1:0]     cursor_reg;
    logic [SEQ_W-1:0]     cursor_next;
    logic [SEQ_W-1:0]     last_read_reg;
    logic [SEQ_W-1:0]     last_read_next;
    logic [1:0]           slot_state_reg [RING_SIZE];

    logic [RING_BITS-1:0] addr;
    logic [1:0]           cur_state;
    logic                 full;
    logic                 wr_en;
    logic [1:0]           wr_state;
    logic [1:0]           sts;
    logic [SEQ_W-1:0]     seq_out;
    logic [SLOT_W-1:0]    mask4;

    // Claim looks at the cursor's slot, everything else at the given sequence
    assign addr      = (req.func == FN_CLAIM) ? cursor_reg[RING_BITS-1:0]
                                              : req.seq_index[RING_BITS-1:0];
    assign cur_state = slot_state_reg[addr];
    assign full      = last_read_reg[RING_BITS-1:0] == cursor_reg[RING_BITS-1:0];
    assign mask4     = RING_MASK[SLOT_W-1:0];

    always_comb
    begin
        sts            = STS_OK;
        seq_out        = req.seq_index;
        wr_en          = 1'b0;
        wr_state       = SLOT_FREE;
        cursor_next    = cursor_reg;
        last_read_next = last_read_reg;
        unique case (req.func)
            FN_CLAIM:
            begin
                if (full)
                    sts = STS_FULL_RETRY;
                else if (cur_state != SLOT_FREE)
                    sts = STS_WRONG_STATE;
                else
                begin
                    seq_out     = cursor_reg;
                    wr_en       = 1'b1;
                    wr_state    = SLOT_CLAIMED;
                    cursor_next = cursor_reg + SEQ_W'(1);
                end
            end
            FN_COMMIT:
            begin
                if (cur_state != SLOT_CLAIMED)
                    sts = STS_WRONG_STATE;
                else
                begin
                    wr_en    = 1'b1;
                    wr_state = SLOT_COMMITTED;
                end
            end
            FN_READ:
            begin
                if (cur_state != SLOT_COMMITTED)
                    sts = STS_NOT_COMMITTED;
                else
                begin
                    wr_en          = 1'b1;
                    wr_state       = SLOT_CLAIMED;
                    last_read_next = req.seq_index;
                end
            end
            default:
            begin
                if (cur_state != SLOT_CLAIMED)
                    sts = STS_WRONG_STATE;
                else
                begin
                    wr_en    = 1'b1;
                    wr_state = SLOT_FREE;
                end
            end
        endcase
    end

    assign result.status      = sts;
    assign result.granted_seq = seq_out;
    assign result.slot_number = seq_out[SLOT_W-1:0] & mask4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            last_read_reg <= '1;
            for (int i = 0; i < RING_SIZE; i++)
                slot_state_reg[i] <= SLOT_FREE;
        end
        else if (fire)
        begin
            cursor_reg    <= cursor_next;
            last_read_reg <= last_read_next;
            if (wr_en)
                slot_state_reg[addr] <= wr_state;
        end
    end

    // A granted claim advances the cursor by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.func == FN_CLAIM && sts == STS_OK
        |=> cursor_reg == $past(cursor_reg) + 32'd1)
        else $error("cursor did not advance on granted claim");

    // A retry or error leaves cursor and read sequence untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && sts != STS_OK
        |=> $stable(cursor_reg) && $stable(last_read_reg))
        else $error("state changed on failed transaction");

    // A successful read records its sequence number
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.func == FN_READ && sts == STS_OK
        |=> last_read_reg == $past(req.seq_index))
        else $error("read sequence not recorded");

    // Only a granted claim ever returns a sequence other than the one given
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !(req.func == FN_CLAIM && sts == STS_OK)
        |-> seq_out == req.seq_index)
        else $error("sequence not echoed");

endmodule

// ===== rtl/core/ring_slot_sequencer_core.sv =====
// Top level of the ring slot sequencer: input register, engine, result register.
// Depends on rss_pkg and rss_engine.
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, func, seq_index     | request
//  out     | out_valid, out_ready, status,           | result
//          | granted_seq, slot_number                |
//
// One transaction per cycle sustained while out_ready stays high; the input
// register loads at the accepting edge, and the result register loads from it
// whenever the result register is empty or being drained.
// The slot state table is a row of flip-flops cleared directly by rst_n, so
// the block takes transactions as soon as rst_n is released.
// A stalled result holds the result register and, once the input register is
// also full, drops in_ready; nothing is lost or reordered.
module ring_slot_sequencer_core
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [SEQ_W-1:0]  seq_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [SEQ_W-1:0]  granted_seq,
    output logic [SLOT_W-1:0] slot_number
);

    logic        req_valid_reg;
    rss_req_t    req_reg;
    logic        res_valid_reg;
    rss_result_t res_reg;
    rss_result_t eng_result;
    logic        advance;

    // Advance the held request into the result register whenever the result
    // register is empty or being drained this cycle. State updates happen here,
    // so transactions act on the state strictly in acceptance order.
    assign advance  = req_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                req_valid_reg <= in_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.func      <= func;
            req_reg.seq_index <= seq_index;
        end
        if (advance)
            res_reg <= eng_result;
    end

    rss_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .req    (req_reg),
        .result (eng_result)
    );

    assign out_valid   = res_valid_reg;
    assign status      = res_reg.status;
    assign granted_seq = res_reg.granted_seq;
    assign slot_number = res_reg.slot_number;

    // A result waiting for the consumer is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !out_ready |-> !advance)
        else $error("pending result overwritten");

    // A request is only taken when the input register has room
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !advance |-> !in_ready)
        else $error("input register overrun");

    // Every advanced transaction shows up as a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("advanced transaction lost");

endmodule

// ===== bench/ring_slot_sequencer_core_tb.sv =====
// Self-checking bench for ring_slot_sequencer_core: directed and random slot
// traffic with a slot ledger that predicts every result and checks it in order.
// Depends on rss_pkg and the ring_slot_sequencer_core RTL.
`timescale 1ns / 100ps

import rss_pkg::*;

// Ledger of ring slot phases. It predicts the result of each accepted request
// and checks each delivered result against the oldest prediction.
class ring_ledger;
    logic [1:0]  slot_phase [RING_SIZE];
    logic [31:0] cursor;
    logic [31:0] last_read;
    rss_result_t pending_results [$];
    int          failures;

    function new();
        cursor    = '0;
        last_read = '1;
        failures  = 0;
        foreach (slot_phase[i])
            slot_phase[i] = SLOT_FREE;
    endfunction

    // Apply one request to the ledger and work out what the block must return.
    function rss_result_t resolve(input logic [1:0] op, input logic [31:0] seq);
        rss_result_t outcome;
        logic [31:0] idx;
        logic [31:0] cidx;
        idx                 = seq & RING_MASK;
        cidx                = cursor & RING_MASK;
        outcome.status      = STS_OK;
        outcome.granted_seq = seq;
        case (op)
            FN_CLAIM:
            begin
                if ((last_read & RING_MASK) == cidx)
                    outcome.status = STS_FULL_RETRY;
                else if (slot_phase[cidx] != SLOT_FREE)
                    outcome.status = STS_WRONG_STATE;
                else
                begin
                    outcome.granted_seq = cursor;
                    slot_phase[cidx]    = SLOT_CLAIMED;
                    cursor              = cursor + 32'd1;
                end
            end
            FN_COMMIT:
            begin
                if (slot_phase[idx] != SLOT_CLAIMED)
                    outcome.status = STS_WRONG_STATE;
                else
                    slot_phase[idx] = SLOT_COMMITTED;
            end
            FN_READ:
            begin
                if (slot_phase[idx] != SLOT_COMMITTED)
                    outcome.status = STS_NOT_COMMITTED;
                else
                begin
                    slot_phase[idx] = SLOT_CLAIMED;
                    last_read       = seq;
                end
            end
            default:
            begin
                if (slot_phase[idx] != SLOT_CLAIMED)
                    outcome.status = STS_WRONG_STATE;
                else
                    slot_phase[idx] = SLOT_FREE;
            end
        endcase
        outcome.slot_number = SLOT_W'(outcome.granted_seq & RING_MASK);
        return outcome;
    endfunction

    function void note_request(input logic [1:0] op, input logic [31:0] seq);
        pending_results.push_back(resolve(op, seq));
    endfunction

    function void check_result(input logic [1:0] st, input logic [31:0] gs,
                               input logic [SLOT_W-1:0] sn);
        rss_result_t want;
        if (pending_results.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: status %0d seq %h slot %0d", st, gs, sn);
        end
        else
        begin
            want = pending_results.pop_front();
            if (want.status !== st || want.granted_seq !== gs || want.slot_number !== sn)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected status %0d seq %h slot %0d, got %0d %h %0d",
                             want.status, want.granted_seq, want.slot_number, st, gs, sn);
            end
        end
    endfunction

    // Pick a slot in the given phase, scanning from a random start; -1 if none.
    function int find_slot(input logic [1:0] phase);
        int start;
        int idx;
        start = $urandom_range(0, RING_SIZE - 1);
        for (int k = 0; k < RING_SIZE; k++)
        begin
            idx = (start + k) % RING_SIZE;
            if (slot_phase[idx] == phase)
                return idx;
        end
        return -1;
    endfunction
endclass

module ring_slot_sequencer_core_tb;
    localparam int ITEM_COUNT      = 700;
    localparam int PRESSURE_AT     = 250;
    localparam int PRESSURE_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic [1:0]        func        = FN_CLAIM;
    logic [SEQ_W-1:0]  seq_index   = '0;
    logic              out_ready   = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic [1:0]        status;
    logic [SEQ_W-1:0]  granted_seq;
    logic [SLOT_W-1:0] slot_number;

    ring_ledger ledger = new();
    int         items_sent    = 0;
    int         results_taken = 0;
    int         cycle_count   = 0;

    ring_slot_sequencer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .seq_index   (seq_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .granted_seq (granted_seq),
        .slot_number (slot_number)
    );

    always #4 clk = ~clk;

    // Watchdog: abandon the run if the traffic never drains.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ring_slot_sequencer_core_tb: done, errors");
            $finish;
        end
    end

    // Offer one request and hold it until the block takes the transaction.
    // Every third stretch of 64 requests goes without gaps.
    task automatic send_transaction(input logic [1:0] op, input logic [31:0] seq);
        int gap;
        gap = ((items_sent / 64) % 3 == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= op;
        seq_index <= seq;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.note_request(op, seq);
        items_sent++;
    endtask

    // Mostly well-formed slot traffic aimed at slots in the right phase, with
    // random high sequence bits; the rest is noise with any operation.
    task automatic random_request();
        int          pick;
        int          idx;
        logic [1:0]  op;
        logic [31:0] seq;
        pick = $urandom_range(0, 99);
        seq  = $urandom;
        idx  = -1;
        if (pick < 15)
            op = 2'($urandom_range(0, 3));
        else if (pick < 45)
            op = FN_CLAIM;
        else if (pick < 65)
        begin
            op  = FN_COMMIT;
            idx = ledger.find_slot(SLOT_CLAIMED);
        end
        else if (pick < 85)
        begin
            op  = FN_READ;
            idx = ledger.find_slot(SLOT_COMMITTED);
        end
        else
        begin
            op  = FN_RELEASE;
            idx = ledger.find_slot(SLOT_CLAIMED);
        end
        if (idx >= 0)
            seq = (seq & ~RING_MASK) | 32'(idx);
        send_transaction(op, seq);
    endtask

    // Result side: random back-pressure, calm stretches, and one long hold-off
    // that lets the block fill up and drop in_ready.
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_taken == PRESSURE_AT)
                hold = PRESSURE_CYCLES;
            else if ((results_taken / 64) % 3 == 1)
                hold = 0;
            else
                hold = $urandom_range(0, 11);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            ledger.check_result(status, granted_seq, slot_number);
            results_taken++;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Claim from reset, ignoring an all-ones index, then walk slot 0
        // through commit, read and release at extreme sequence numbers.
        send_transaction(FN_CLAIM, 32'hFFFF_FFFF);
        send_transaction(FN_COMMIT, 32'hFFFF_FFF0);
        send_transaction(FN_READ, 32'h0000_0000);
        // Read of a slot that is only claimed
        send_transaction(FN_READ, 32'h0000_0010);
        // Release and commit of free slots, then the release of slot 0
        send_transaction(FN_RELEASE, 32'hFFFF_FFFF);
        send_transaction(FN_COMMIT, 32'h0000_0005);
        send_transaction(FN_RELEASE, 32'h8000_0000);
        // Claim round the ring until the cursor meets the last-read slot
        for (int k = 0; k < RING_SIZE; k++)
            send_transaction(FN_CLAIM, $urandom);
        // Move the read point on, claim the freed slot 0, then claim into a busy slot
        send_transaction(FN_COMMIT, 32'h0000_0003);
        send_transaction(FN_READ, 32'h0000_0003);
        send_transaction(FN_CLAIM, 32'h0000_0000);
        send_transaction(FN_CLAIM, 32'h0000_0000);

        repeat (ITEM_COUNT) random_request();
        in_valid <= 1'b0;

        // Drain, then wait out DRAIN_CYCLES so that any stray result shows.
        while (ledger.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.pending_results.size() != 0)
        begin
            ledger.failures++;
            $display("%0d results never arrived", ledger.pending_results.size());
        end

        if (ledger.failures == 0)
            $display("ring_slot_sequencer_core_tb: done, clean");
        else
            $display("ring_slot_sequencer_core_tb: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/rss_pkg.sv
rtl/core/rss_engine.sv
rtl/core/ring_slot_sequencer_core.sv
bench/ring_slot_sequencer_core_tb.sv
